/* src/hsg_pkg.sv */
// Shared types and constants of the homing step generator.
// Used by every module in src; depends on nothing.
package hsg_pkg;

  localparam int unsigned AXES       = 3;
  localparam int unsigned STEPS_W    = 16;
  localparam int unsigned CNT_W      = 18;
  localparam int unsigned DELAY_W    = 24;
  localparam int unsigned RATE_W     = 32;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [DELAY_W-1:0] ACCEL_TICK_US  = DELAY_W'(20000);
  localparam logic [DELAY_W-1:0] START_DELAY_US = DELAY_W'(75000);
  localparam logic [DELAY_W-1:0] CRUISE_RESET   = DELAY_W'(1000);
  localparam int unsigned US_PER_MINUTE = 60000000;
  localparam int unsigned QUOT_W        = $clog2(US_PER_MINUTE + 1);
  localparam int unsigned ITER_W        = $clog2(QUOT_W);
  localparam logic [QUOT_W-1:0] DIVIDEND = QUOT_W'(US_PER_MINUTE);

  localparam logic [CFG_IDX_W-1:0] REG_AXIS_MASK    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEAVE_SWITCH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_Z      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_INC    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_DELAY = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_BITS    = 3'd7;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef struct packed {
    logic       command;
    logic [2:0] limit_levels;
    logic       abort;
  } hsg_in_t;

  typedef struct packed {
    logic [2:0]         step_pulses;
    logic [2:0]         direction_levels;
    logic [DELAY_W-1:0] next_delay_us;
    logic               done_res;
  } hsg_out_t;

  typedef struct packed {
    logic load;
    logic advance;
  } hsg_axis_ctrl_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } hsg_div_res_t;

endpackage

/* src/hsg_axis.sv */
// Bresenham counter of one axis with its latched step count.
// Depends on hsg_pkg.
module hsg_axis (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hsg_pkg::hsg_axis_ctrl_t      ctrl_i,
  input  logic [hsg_pkg::STEPS_W-1:0]  steps_i,
  input  logic [hsg_pkg::CNT_W-1:0]    start_value_i,
  input  logic [hsg_pkg::STEPS_W-1:0]  event_count_i,
  output logic                         fire_o
);
  import hsg_pkg::*;

  logic [CNT_W-1:0]   count_q, count_d;
  logic [STEPS_W-1:0] held_q, held_d;
  logic [CNT_W-1:0]   sum;

  assign sum    = count_q + CNT_W'(held_q);
  assign fire_o = !sum[CNT_W-1] && (sum != '0);

  always_comb begin
    count_d = count_q;
    held_d  = held_q;
    if (ctrl_i.load) begin
      count_d = start_value_i;
      held_d  = steps_i;
    end else if (ctrl_i.advance) begin
      count_d = fire_o ? sum - CNT_W'(event_count_i) : sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      held_q  <= '0;
    end else begin
      count_q <= count_d;
      held_q  <= held_d;
    end
  end

endmodule

/* src/hsg_divider.sv */
// Bit-serial restoring divider that computes the microseconds per minute over the rate.
// One quotient bit per cycle; depends on hsg_pkg.
module hsg_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [hsg_pkg::RATE_W-1:0]  divisor_i,
  output hsg_pkg::hsg_div_res_t       res_o
);
  import hsg_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic [RATE_W-1:0] rem_q, rem_d;
  logic [RATE_W-1:0] div_q, div_d;
  logic [QUOT_W-1:0] shift_q, shift_d;
  logic [RATE_W:0]   trial;
  logic [RATE_W:0]   diff;
  logic              ge;

  assign trial = {rem_q, shift_q[QUOT_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = trial >= {1'b0, div_q};

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    iter_d  = iter_q;
    rem_d   = rem_q;
    div_d   = div_q;
    shift_d = shift_q;
    if (start_i) begin
      busy_d  = 1'b1;
      iter_d  = '0;
      rem_d   = '0;
      div_d   = divisor_i;
      shift_d = DIVIDEND;
    end else if (busy_q) begin
      rem_d   = ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
      shift_d = {shift_q[QUOT_W-2:0], ge};
      iter_d  = iter_q + 1'b1;
      if (iter_q == ITER_W'(QUOT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    div_q   <= div_d;
    shift_q <= shift_d;
  end

  assign res_o.done     = done_q;
  assign res_o.quotient = shift_q;

endmodule

/* src/homing_step_generator.sv */
// Three-axis homing step generator: start and step requests in, one result request out.
// A result waits in the skid entry while the output stalls. The next request is taken
// in the following cycle unless the skid entry is full or an acceleration tick runs
// the 26-bit serial rate divider. Reset is asynchronous and active low; it restores
// the register defaults and clears the axis state, rate, delay and trapezoid counter.
module homing_step_generator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  hsg_pkg::hsg_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output hsg_pkg::hsg_out_t              out_data_o,
  input  logic                           cfg_we_i,
  input  logic [hsg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hsg_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import hsg_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic [2:0]         mask_q;
  logic               leave_q;
  logic [STEPS_W-1:0] steps_q [AXES];
  logic [DELAY_W-1:0] inc_q;
  logic [DELAY_W-1:0] cruise_q;
  logic [5:0]         base_q;

  logic               state_q, state_d;
  logic [2:0]         active_q, active_d;
  logic [DELAY_W-1:0] delay_q, delay_d;
  logic [RATE_W-1:0]  rate_q, rate_d;
  logic [DELAY_W-1:0] trap_q, trap_d;
  logic [STEPS_W-1:0] event_q, event_d;
  logic [DELAY_W-1:0] clamp_q, clamp_d;

  hsg_out_t out_q, out_d, pend_q, pend_d, res;
  logic     out_valid_q, out_valid_d, pend_valid_q, pend_valid_d;

  hsg_axis_ctrl_t     axis_ctrl [AXES];
  logic [STEPS_W-1:0] axis_steps [AXES];
  logic [2:0]         fire;
  logic [CNT_W-1:0]   start_value;
  logic [STEPS_W-1:0] max_steps;

  hsg_div_res_t       div_res;
  logic               div_start;

  logic               in_fire, is_step, is_start, out_free;
  logic [2:0]         limits, pulses, active_step;
  logic               all_done;
  logic [DELAY_W:0]   trap_sum;
  logic [DELAY_W-1:0] trap_sat;
  logic               tick;
  logic [RATE_W:0]    rate_sum;
  logic [RATE_W-1:0]  rate_sat;
  logic [QUOT_W-1:0]  quot_clamped;

  assign in_stall_o = (state_q != ST_IDLE) || pend_valid_q;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign is_start   = in_fire && (in_data_i.command == CMD_START);
  assign is_step    = in_fire && (in_data_i.command == CMD_STEP);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= 3'b111;
      leave_q  <= 1'b0;
      steps_q  <= '{default: '0};
      inc_q    <= '0;
      cruise_q <= CRUISE_RESET;
      base_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_AXIS_MASK:    mask_q     <= cfg_data_i[2:0];
        REG_LEAVE_SWITCH: leave_q    <= cfg_data_i[0];
        REG_STEPS_X:      steps_q[0] <= cfg_data_i[STEPS_W-1:0];
        REG_STEPS_Y:      steps_q[1] <= cfg_data_i[STEPS_W-1:0];
        REG_STEPS_Z:      steps_q[2] <= cfg_data_i[STEPS_W-1:0];
        REG_ACCEL_INC:    inc_q      <= cfg_data_i;
        REG_CRUISE_DELAY: cruise_q   <= cfg_data_i;
        REG_BASE_BITS:    base_q     <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    max_steps = '0;
    for (int i = 0; i < AXES; i++) begin
      axis_steps[i] = mask_q[i] ? steps_q[i] : '0;
      if (axis_steps[i] > max_steps) max_steps = axis_steps[i];
    end
  end

  assign start_value = '0 - CNT_W'(max_steps[STEPS_W-1:1]);

  for (genvar g = 0; g < AXES; g++) begin : g_axis
    assign axis_ctrl[g] = '{load: is_start, advance: is_step && active_q[g]};
    hsg_axis u_axis (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (axis_ctrl[g]),
      .steps_i       (axis_steps[g]),
      .start_value_i (start_value),
      .event_count_i (event_q),
      .fire_o        (fire[g])
    );
  end

  hsg_divider u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (rate_sat),
    .res_o     (div_res)
  );

  assign limits = in_data_i.limit_levels ^ {3{leave_q}};

  always_comb begin
    pulses      = base_q[2:0];
    active_step = active_q;
    for (int i = 0; i < AXES; i++) begin
      if (active_q[i] && fire[i]) begin
        if (limits[i]) pulses[i] = ~pulses[i];
        else           active_step[i] = 1'b0;
      end
    end
  end

  assign all_done = (active_step == '0) || in_data_i.abort;

  assign trap_sum = {1'b0, trap_q} + {1'b0, delay_q};
  assign trap_sat = trap_sum[DELAY_W] ? '1 : trap_sum[DELAY_W-1:0];
  assign tick     = trap_sat > ACCEL_TICK_US;
  assign rate_sum = {1'b0, rate_q} + (RATE_W+1)'(inc_q);
  assign rate_sat = rate_sum[RATE_W] ? '1 : rate_sum[RATE_W-1:0];

  always_comb begin
    quot_clamped = div_res.quotient;
    if (quot_clamped < QUOT_W'(clamp_q)) quot_clamped = QUOT_W'(clamp_q);
  end

  always_comb begin
    state_d   = state_q;
    active_d  = active_q;
    delay_d   = delay_q;
    rate_d    = rate_q;
    trap_d    = trap_q;
    event_d   = event_q;
    clamp_d   = clamp_q;
    div_start = 1'b0;
    res.step_pulses      = base_q[2:0];
    res.direction_levels = base_q[5:3];
    res.next_delay_us    = delay_q;
    res.done_res         = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (is_start) begin
          event_d  = max_steps;
          active_d = mask_q;
          delay_d  = (START_DELAY_US > cruise_q) ? cruise_q : START_DELAY_US;
          rate_d   = '0;
          trap_d   = ACCEL_TICK_US >> 1;
          res.next_delay_us = delay_d;
        end else if (is_step) begin
          if (all_done) begin
            active_d          = '0;
            res.next_delay_us = '0;
            res.done_res      = 1'b1;
          end else begin
            active_d        = active_step;
            res.step_pulses = pulses;
            if (delay_q > cruise_q) begin
              trap_d = tick ? trap_sat - ACCEL_TICK_US : trap_sat;
              if (tick) begin
                rate_d  = rate_sat;
                clamp_d = cruise_q;
                if (rate_sat != '0) begin
                  div_start = 1'b1;
                  state_d   = ST_DIV;
                end
              end
            end
          end
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_d = ST_IDLE;
          delay_d = (quot_clamped > QUOT_W'({DELAY_W{1'b1}})) ? '1
                                                               : quot_clamped[DELAY_W-1:0];
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output register with one skid entry behind it.
  always_comb begin
    out_d        = out_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q;
    pend_valid_d = pend_valid_q;
    if (in_fire) begin
      if (out_free) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        pend_d       = res;
        pend_valid_d = 1'b1;
      end
    end else if (out_free) begin
      out_d        = pend_q;
      out_valid_d  = pend_valid_q;
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      active_q     <= '0;
      delay_q      <= '0;
      rate_q       <= '0;
      trap_q       <= '0;
      event_q      <= '0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      active_q     <= active_d;
      delay_q      <= delay_d;
      rate_q       <= rate_d;
      trap_q       <= trap_d;
      event_q      <= event_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    pend_q  <= pend_d;
    clamp_q <= clamp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_pend_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q)
    else $error("Skid entry holds a result while the output register is empty.");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (state_q == ST_DIV))
    else $error("Divider finished outside of a divide.");

  a_done_clears_axes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && res.done_res) |=> (active_q == '0))
    else $error("Axes still active after a done result.");

  a_div_start_on_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (is_step && (rate_sat != '0)))
    else $error("Divider started without a step request and a nonzero rate.");

endmodule

/* tb/homing_step_generator_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for homing_step_generator. It holds its own model of the axes,
// the acceleration ramp and the register file, and checks every result. Depends on hsg_pkg.
module homing_step_generator_tb;
  import hsg_pkg::*;

  typedef struct {
    logic       is_cfg;
    logic [2:0] idx;
    logic [23:0] data;
    hsg_in_t    req;
    logic       typed;
    hsg_out_t   want;
  } plan_row_t;

  typedef struct {
    hsg_out_t model;
    logic     typed;
    hsg_out_t typed_val;
  } awaited_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  hsg_in_t               in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  hsg_out_t              out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Register shadow.
  logic [2:0]         sh_mask;
  logic               sh_leave;
  logic [15:0]        sh_steps [3];
  logic [23:0]        sh_accel;
  logic [23:0]        sh_cruise;
  logic [5:0]         sh_base;

  // Motion state of the model.
  logic [2:0]         live_axes;
  logic [CNT_W-1:0]   bres_cnt [3];
  logic [15:0]        latched_steps [3];
  logic [15:0]        event_total;
  logic [DELAY_W-1:0] cur_delay;
  logic [RATE_W-1:0]  cur_rate;
  logic [DELAY_W-1:0] ramp_acc;

  awaited_t   awaited_results [$];
  awaited_t   head;
  plan_row_t  plan [$];
  logic       next_typed;
  hsg_out_t   next_want;
  int         send_idle_pct;
  int         recv_stall_pct;
  int         errors;
  int         n_requests;
  int         n_starts;
  int         n_aborts;
  int         n_results;
  int         ramp_ticks;

  homing_step_generator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results still awaited", awaited_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void shadow_reset();
    sh_mask = 3'd7;
    sh_leave = 1'b0;
    sh_accel = '0;
    sh_cruise = CRUISE_RESET;
    sh_base = '0;
    live_axes = '0;
    event_total = '0;
    cur_delay = '0;
    cur_rate = '0;
    ramp_acc = '0;
    for (int i = 0; i < 3; i++) begin
      sh_steps[i] = '0;
      bres_cnt[i] = '0;
      latched_steps[i] = '0;
    end
  endfunction

  function automatic void shadow_write(logic [2:0] idx, logic [23:0] d);
    case (idx)
      REG_AXIS_MASK:    sh_mask = d[2:0];
      REG_LEAVE_SWITCH: sh_leave = d[0];
      REG_STEPS_X:      sh_steps[0] = d[15:0];
      REG_STEPS_Y:      sh_steps[1] = d[15:0];
      REG_STEPS_Z:      sh_steps[2] = d[15:0];
      REG_ACCEL_INC:    sh_accel = d;
      REG_CRUISE_DELAY: sh_cruise = d;
      REG_BASE_BITS:    sh_base = d[5:0];
      default: ;
    endcase
  endfunction

  function automatic hsg_out_t homing_response(hsg_in_t req);
    hsg_out_t    r;
    logic [2:0]  lim;
    logic [24:0] acc_sum;
    logic [32:0] rate_sum;
    logic [31:0] d;
    r.step_pulses = sh_base[2:0];
    r.direction_levels = sh_base[5:3];
    r.next_delay_us = '0;
    r.done_res = 1'b0;
    if (req.command == CMD_START) begin
      event_total = '0;
      for (int i = 0; i < 3; i++) begin
        latched_steps[i] = sh_mask[i] ? sh_steps[i] : 16'd0;
        if (latched_steps[i] > event_total) event_total = latched_steps[i];
      end
      for (int i = 0; i < 3; i++) bres_cnt[i] = CNT_W'(0) - CNT_W'(event_total >> 1);
      live_axes = sh_mask;
      cur_delay = (START_DELAY_US > sh_cruise) ? sh_cruise : START_DELAY_US;
      cur_rate = '0;
      ramp_acc = ACCEL_TICK_US >> 1;
      r.next_delay_us = cur_delay;
      return r;
    end
    lim = req.limit_levels ^ {3{sh_leave}};
    for (int i = 0; i < 3; i++) begin
      if (live_axes[i]) begin
        bres_cnt[i] = bres_cnt[i] + CNT_W'(latched_steps[i]);
        if ($signed(bres_cnt[i]) > 0) begin
          if (lim[i]) r.step_pulses[i] = ~r.step_pulses[i];
          else live_axes[i] = 1'b0;
          bres_cnt[i] = bres_cnt[i] - CNT_W'(event_total);
        end
      end
    end
    if (live_axes == 3'd0 || req.abort) begin
      live_axes = '0;
      r.step_pulses = sh_base[2:0];
      r.done_res = 1'b1;
      return r;
    end
    r.next_delay_us = cur_delay;
    if (cur_delay > sh_cruise) begin
      acc_sum = {1'b0, ramp_acc} + {1'b0, cur_delay};
      ramp_acc = acc_sum[24] ? '1 : acc_sum[23:0];
      if (ramp_acc > ACCEL_TICK_US) begin
        ramp_acc = ramp_acc - ACCEL_TICK_US;
        rate_sum = {1'b0, cur_rate} + 33'(sh_accel);
        cur_rate = rate_sum[32] ? '1 : rate_sum[31:0];
        d = 32'(cur_delay);
        if (cur_rate != 0) d = US_PER_MINUTE / cur_rate;
        if (d < 32'(sh_cruise)) d = 32'(sh_cruise);
        cur_delay = (d > 32'hFF_FFFF) ? '1 : d[23:0];
        ramp_ticks++;
      end
    end
    return r;
  endfunction

  task automatic compare_result(hsg_out_t got, hsg_out_t want);
    if (got.step_pulses !== want.step_pulses || got.direction_levels !== want.direction_levels
        || got.next_delay_us !== want.next_delay_us || got.done_res !== want.done_res) begin
      errors++;
      $display("%0t: mismatch expected pulses=%b dir=%b delay=%0d done=%b,",
               $time, want.step_pulses, want.direction_levels, want.next_delay_us,
               want.done_res, " got pulses=%b dir=%b delay=%0d done=%b",
               got.step_pulses, got.direction_levels, got.next_delay_us, got.done_res);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && cfg_we_i) shadow_write(cfg_idx_i, cfg_data_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      awaited_results.push_back(awaited_t'{homing_response(in_data_i), next_typed, next_want});
      n_requests++;
      if (in_data_i.command == CMD_START) n_starts++;
      else if (in_data_i.abort) n_aborts++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %p", $time, out_data_o);
      end else begin
        head = awaited_results.pop_front();
        compare_result(out_data_o, head.model);
        if (head.typed) compare_result(out_data_o, head.typed_val);
        n_results++;
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_req(hsg_in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [23:0] d);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  function automatic void plan_cfg(logic [2:0] idx, logic [23:0] d);
    plan.push_back(plan_row_t'{1'b1, idx, d, hsg_in_t'(0), 1'b0, hsg_out_t'(0)});
  endfunction

  function automatic void plan_req(hsg_in_t req, logic typed, hsg_out_t want);
    plan.push_back(plan_row_t'{1'b0, 3'd0, 24'd0, req, typed, want});
  endfunction

  function automatic logic [15:0] pick_steps();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic [23:0] pick_accel();
    case ($urandom_range(4))
      0: return 24'd0;
      1: return 24'hFF_FFFF;
      2: return 24'($urandom_range(1, 100));
      3: return 24'($urandom_range(1000, 200000));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_cruise();
    case ($urandom_range(5))
      0: return 24'hFF_FFFF;
      1: return 24'd1;
      2: return 24'($urandom_range(1, 74999));
      3: return 24'($urandom);
      default: return 24'($urandom_range(75001, 16777215));
    endcase
  endfunction

  task automatic random_cycle(int quota);
    hsg_in_t    req;
    int         n_steps;
    logic [2:0] free_lvl;
    settle();
    if ($urandom_range(99) < 70) begin
      cfg_write(REG_AXIS_MASK, ($urandom_range(3) == 0) ? 24'($urandom_range(7)) : 24'd7);
      cfg_write(REG_LEAVE_SWITCH, 24'($urandom_range(1)));
      cfg_write(REG_STEPS_X, 24'(pick_steps()));
      cfg_write(REG_STEPS_Y, 24'(pick_steps()));
      cfg_write(REG_STEPS_Z, 24'(pick_steps()));
      cfg_write(REG_ACCEL_INC, pick_accel());
      cfg_write(REG_CRUISE_DELAY, pick_cruise());
      cfg_write(REG_BASE_BITS, 24'($urandom_range(63)));
      cfg_we_i <= 1'b0;
    end
    send_req(hsg_in_t'{CMD_START, 3'($urandom), 1'($urandom)});
    if ($urandom_range(99) < 60) begin
      settle();
      cfg_write(REG_CRUISE_DELAY,
                ($urandom_range(19) == 0) ? 24'd0 : 24'($urandom_range(1, 74999)));
      if ($urandom_range(1) == 1) cfg_write(REG_ACCEL_INC, pick_accel());
      cfg_we_i <= 1'b0;
    end
    n_steps = $urandom_range(1, 30);
    while (n_steps > 0 && n_requests < quota) begin
      free_lvl = sh_leave ? 3'b000 : 3'b111;
      req.command = ($urandom_range(49) == 0) ? CMD_START : CMD_STEP;
      req.limit_levels = ($urandom_range(99) < 85) ? free_lvl : 3'($urandom);
      req.abort = ($urandom_range(99) < 3);
      send_req(req);
      n_steps--;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    next_typed = 1'b0;
    next_want = '0;
    send_idle_pct = 9;
    recv_stall_pct = 55;
    errors = 0;
    n_requests = 0;
    n_starts = 0;
    n_aborts = 0;
    n_results = 0;
    ramp_ticks = 0;
    shadow_reset();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Idle behavior after reset, then a cycle with every count at zero.
    plan_req(hsg_in_t'{CMD_STEP, 3'b111, 1'b0}, 1'b1, hsg_out_t'{3'd0, 3'd0, 24'd0, 1'b1});
    plan_req(hsg_in_t'{CMD_START, 3'b000, 1'b1}, 1'b1, hsg_out_t'{3'd0, 3'd0, 24'd1000, 1'b0});
    plan_req(hsg_in_t'{CMD_STEP, 3'b111, 1'b0}, 1'b1, hsg_out_t'{3'd0, 3'd0, 24'd1000, 1'b0});
    plan_req(hsg_in_t'{CMD_STEP, 3'b111, 1'b1}, 1'b1, hsg_out_t'{3'd0, 3'd0, 24'd0, 1'b1});
    // Register extremes with inverted limit levels.
    plan_cfg(REG_BASE_BITS, 24'd63);
    plan_cfg(REG_STEPS_X, 24'hFFFF);
    plan_cfg(REG_STEPS_Y, 24'd1);
    plan_cfg(REG_STEPS_Z, 24'd0);
    plan_cfg(REG_ACCEL_INC, 24'hFF_FFFF);
    plan_cfg(REG_CRUISE_DELAY, 24'hFF_FFFF);
    plan_cfg(REG_LEAVE_SWITCH, 24'd1);
    plan_cfg(REG_AXIS_MASK, 24'd7);
    plan_req(hsg_in_t'{CMD_START, 3'b111, 1'b0}, 1'b1, hsg_out_t'{3'd7, 3'd7, 24'd75000, 1'b0});
    plan_req(hsg_in_t'{CMD_STEP, 3'b000, 1'b0}, 1'b0, hsg_out_t'(0));
    plan_req(hsg_in_t'{CMD_STEP, 3'b000, 1'b0}, 1'b0, hsg_out_t'(0));
    plan_req(hsg_in_t'{CMD_STEP, 3'b111, 1'b0}, 1'b0, hsg_out_t'(0));
    plan_req(hsg_in_t'{CMD_STEP, 3'b000, 1'b1}, 1'b1, hsg_out_t'{3'd7, 3'd7, 24'd0, 1'b1});
    // Acceleration after the cruise delay drops below the start delay.
    plan_cfg(REG_CRUISE_DELAY, 24'd100000);
    plan_cfg(REG_STEPS_X, 24'd3);
    plan_cfg(REG_STEPS_Y, 24'd2);
    plan_cfg(REG_STEPS_Z, 24'd1);
    plan_cfg(REG_LEAVE_SWITCH, 24'd0);
    plan_cfg(REG_BASE_BITS, 24'd42);
    plan_req(hsg_in_t'{CMD_START, 3'b111, 1'b0}, 1'b1, hsg_out_t'{3'd2, 3'd5, 24'd75000, 1'b0});
    plan_cfg(REG_CRUISE_DELAY, 24'd1);
    for (int k = 0; k < 5; k++) plan_req(hsg_in_t'{CMD_STEP, 3'b111, 1'b0}, 1'b0, hsg_out_t'(0));
    plan_req(hsg_in_t'{CMD_STEP, 3'b011, 1'b0}, 1'b0, hsg_out_t'(0));
    // Slow ramp clamped at the delay limit, zero cruise delay, empty axis mask.
    plan_cfg(REG_ACCEL_INC, 24'd1);
    plan_cfg(REG_CRUISE_DELAY, 24'd100000);
    plan_cfg(REG_AXIS_MASK, 24'd2);
    plan_cfg(REG_STEPS_Y, 24'hFFFF);
    plan_req(hsg_in_t'{CMD_START, 3'b111, 1'b0}, 1'b1, hsg_out_t'{3'd2, 3'd5, 24'd75000, 1'b0});
    plan_cfg(REG_CRUISE_DELAY, 24'd0);
    for (int k = 0; k < 3; k++) plan_req(hsg_in_t'{CMD_STEP, 3'b111, 1'b0}, 1'b0, hsg_out_t'(0));
    plan_req(hsg_in_t'{CMD_STEP, 3'b101, 1'b0}, 1'b1, hsg_out_t'{3'd2, 3'd5, 24'd0, 1'b1});
    plan_cfg(REG_AXIS_MASK, 24'd0);
    plan_req(hsg_in_t'{CMD_START, 3'b111, 1'b0}, 1'b1, hsg_out_t'{3'd2, 3'd5, 24'd0, 1'b0});
    plan_req(hsg_in_t'{CMD_STEP, 3'b111, 1'b0}, 1'b1, hsg_out_t'{3'd2, 3'd5, 24'd0, 1'b1});

    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        if (!cfg_we_i) settle();
        cfg_write(plan[k].idx, plan[k].data);
      end else begin
        cfg_we_i <= 1'b0;
        next_typed = plan[k].typed;
        next_want = plan[k].want;
        send_req(plan[k].req);
      end
    end
    next_typed = 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 55 : 0;
      recv_stall_pct = (phase == 0) ? 55 : (phase == 1) ? 9 : 0;
      for (int quota = n_requests + 150; n_requests < quota; ) random_cycle(quota);
    end
    settle();

    $display("Checked %0d results from %0d requests: %0d starts, %0d aborted steps,",
             n_results, n_requests, n_starts, n_aborts, " %0d ramp ticks.", ramp_ticks);
    $display("Both handshakes ran with sender-heavy, receiver-heavy and no idling.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/hsg_pkg.sv
src/hsg_axis.sv
src/hsg_divider.sv
src/homing_step_generator.sv
tb/homing_step_generator_tb.sv
